// ----- rtl/core/scfr_pkg.sv -----
// Package for the serial command idle framer.
// Holds shared constants, character codes, command words and job kinds.
// No dependencies.
`default_nettype none

package scfr_pkg;

    localparam int C_STORE_BYTES = 4;
    localparam int C_QUEUE_DEPTH = 2;

    localparam logic [15:0] C_IDLE_TIMEOUT_RST = 16'd1000;
    localparam logic [7:0]  C_STORE_OFFSET_RST = 8'h30;

    localparam logic [7:0] C_CHAR_CR = 8'h0D;
    localparam logic [7:0] C_CHAR_LF = 8'h0A;

    localparam logic [31:0] C_WORD_READ = "READ";
    localparam logic [23:0] C_WORD_SET  = "SET";

    localparam logic [4:0] C_LEN_MAX  = 5'd31;
    localparam logic [4:0] C_LEN_READ = 5'd4;
    localparam logic [4:0] C_LEN_SET  = 5'd3;

    localparam logic [15:0] C_IDLE_MAX = 16'hFFFF;

    localparam logic C_CMD_BYTE = 1'b0;
    localparam logic C_CMD_TICK = 1'b1;

    localparam logic C_CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic C_CFG_STORE_OFFSET = 1'b1;

    localparam logic C_KIND_ECHO    = 1'b0;
    localparam logic C_KIND_READOUT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/serial_command_idle_framer.sv -----
// Top level of the serial command idle framer.
// Instantiates scfr_front, scfr_queue and scfr_back; depends on scfr_pkg.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] = rx_byte; tuser[0] = command (0 byte, 1 tick)
// m_axis    out        tdata[7:0] = tx_byte; tuser[0] = source_kind; tlast = last
// cfg       in         i_cfg_we, i_cfg_idx (0 idle_timeout, 1 store_offset), i_cfg_data
//
// An input item can be taken every cycle while the job queue is not full.
// An echo gives one result item a cycle while m_axis_tready holds; a READ readout
// sends P_STORE_BYTES bytes, one byte a cycle from the output register while
// m_axis_tready holds, and no new job is taken until its last byte is loaded.
// A two-entry job queue lets the input side run while the output side stalls.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module serial_command_idle_framer
    import scfr_pkg::*;
#(
    parameter int P_STORE_BYTES = C_STORE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic        s_axis_tuser,  // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] tx_byte
    output logic             m_axis_tuser,  // [0] source_kind
    output logic             m_axis_tlast
);

    localparam int DW = 8 * P_STORE_BYTES;

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic          job_kind;
    logic [DW-1:0] job_data;
    logic [DW:0]   q_out;

    scfr_front #(
        .P_STORE_BYTES(P_STORE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_command  (s_axis_tuser),
        .i_rx_byte  (s_axis_tdata),
        .i_full     (full),
        .o_push     (push),
        .o_job_kind (job_kind),
        .o_job_data (job_data)
    );

    scfr_queue #(
        .P_WIDTH(DW + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({job_kind, job_data}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    scfr_back #(
        .P_STORE_BYTES(P_STORE_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_job_kind (q_out[DW]),
        .i_job_data (q_out[DW-1:0]),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/scfr_queue.sv -----
// Short job queue between the front and back parts of the framer.
// Register based, two entries. Depends on scfr_pkg.
`default_nettype none

module scfr_queue
    import scfr_pkg::*;
#(
    parameter int P_WIDTH = 33
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [P_WIDTH-1:0] i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic      [P_WIDTH-1:0] o_data
);

    localparam int PW = $clog2(C_QUEUE_DEPTH);
    localparam int CW = $clog2(C_QUEUE_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [C_QUEUE_DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;

    assign o_full  = (r_count == CW'(C_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(C_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(C_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/scfr_front.sv -----
// Front part of the framer: accepts items, keeps the command buffer, idle
// counter, collect state and stored bytes, and queues echo or readout jobs.
// Depends on scfr_pkg.
`default_nettype none

module scfr_front
    import scfr_pkg::*;
#(
    parameter int P_STORE_BYTES = C_STORE_BYTES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [15:0]                i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_command,
    input  wire logic [7:0]                 i_rx_byte,
    input  wire logic                       i_full,
    output logic                            o_push,
    output logic                            o_job_kind,
    output logic [8*P_STORE_BYTES-1:0]      o_job_data
);

    localparam int DW = 8 * P_STORE_BYTES;
    localparam int CW = (P_STORE_BYTES > 1) ? $clog2(P_STORE_BYTES) : 1;

    logic [15:0] r_idle_timeout;
    logic [7:0]  r_store_offset;

    logic [7:0]  r_chars [4];
    logic [4:0]  r_len, n_len;
    logic [15:0] r_idle, n_idle;
    logic        r_collecting, n_collecting;
    logic [CW-1:0] r_collect_idx, n_collect_idx;
    logic [P_STORE_BYTES-1:0][7:0] r_stored, n_stored;

    logic        accept;
    logic        chars_we;
    logic [15:0] idle_inc;
    logic        match_read;
    logic        match_set;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign idle_inc   = (r_idle == C_IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign match_read = (r_len == C_LEN_READ) &&
                        ({r_chars[0], r_chars[1], r_chars[2], r_chars[3]} == C_WORD_READ);
    assign match_set  = (r_len == C_LEN_SET) &&
                        ({r_chars[0], r_chars[1], r_chars[2]} == C_WORD_SET);

    always_comb begin
        n_len         = r_len;
        n_idle        = r_idle;
        n_collecting  = r_collecting;
        n_collect_idx = r_collect_idx;
        n_stored      = r_stored;
        chars_we      = 1'b0;
        o_push        = 1'b0;
        o_job_kind    = C_KIND_ECHO;
        o_job_data    = DW'(i_rx_byte);
        if (accept) begin
            if (i_command == C_CMD_BYTE) begin
                n_idle = '0;
                if (r_collecting) begin
                    n_stored[r_collect_idx] = i_rx_byte + r_store_offset;
                    if (r_collect_idx == CW'(P_STORE_BYTES - 1)) begin
                        n_collect_idx = '0;
                        n_collecting  = 1'b0;
                    end else begin
                        n_collect_idx = r_collect_idx + 1'b1;
                    end
                    o_push = 1'b1;
                end else if (i_rx_byte != C_CHAR_CR && i_rx_byte != C_CHAR_LF) begin
                    chars_we = (r_len[4:2] == 3'd0);
                    if (r_len != C_LEN_MAX) begin
                        n_len = r_len + 5'd1;
                    end
                    o_push = 1'b1;
                end
            end else begin
                n_idle = idle_inc;
                if (idle_inc >= r_idle_timeout && r_len != '0) begin
                    if (match_read) begin
                        o_push     = 1'b1;
                        o_job_kind = C_KIND_READOUT;
                        o_job_data = r_stored;
                    end else if (match_set) begin
                        n_collecting  = 1'b1;
                        n_collect_idx = '0;
                    end
                    n_len  = '0;
                    n_idle = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (chars_we) begin
            r_chars[r_len[1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= C_IDLE_TIMEOUT_RST;
            r_store_offset <= C_STORE_OFFSET_RST;
            r_len          <= '0;
            r_idle         <= '0;
            r_collecting   <= 1'b0;
            r_collect_idx  <= '0;
            r_stored       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    C_CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data;
                    C_CFG_STORE_OFFSET: r_store_offset <= i_cfg_data[7:0];
                    default:            r_idle_timeout <= r_idle_timeout;
                endcase
            end
            r_len         <= n_len;
            r_idle        <= n_idle;
            r_collecting  <= n_collecting;
            r_collect_idx <= n_collect_idx;
            r_stored      <= n_stored;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/scfr_back.sv -----
// Back part of the framer: takes jobs from the queue and sends result items
// through a registered output stage. Depends on scfr_pkg.
`default_nettype none

module scfr_back
    import scfr_pkg::*;
#(
    parameter int P_STORE_BYTES = C_STORE_BYTES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    output logic                            o_pop,
    input  wire logic                       i_job_kind,
    input  wire logic [8*P_STORE_BYTES-1:0] i_job_data,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [7:0]                      o_tdata,
    output logic                            o_tuser,
    output logic                            o_tlast
);

    localparam int DW = 8 * P_STORE_BYTES;
    localparam int CW = (P_STORE_BYTES > 1) ? $clog2(P_STORE_BYTES) : 1;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_data;
    logic          r_tvalid;
    logic [7:0]    r_tdata;
    logic          r_tuser;
    logic          r_tlast;
    logic          out_free;
    logic          busy_last;

    assign out_free  = !r_tvalid || i_tready;
    assign o_pop     = out_free && !r_busy && !i_empty;
    assign busy_last = (r_cnt == CW'(P_STORE_BYTES - 1));

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_tvalid <= 1'b0;
        end else if (out_free) begin
            if (r_busy) begin
                r_tvalid <= 1'b1;
                r_tdata  <= r_data[7:0];
                r_tuser  <= C_KIND_READOUT;
                r_tlast  <= busy_last;
                r_data   <= r_data >> 8;
                r_cnt    <= r_cnt + 1'b1;
                if (busy_last) begin
                    r_busy <= 1'b0;
                end
            end else if (!i_empty) begin
                r_tvalid <= 1'b1;
                r_tdata  <= i_job_data[7:0];
                r_tuser  <= i_job_kind;
                if (i_job_kind == C_KIND_READOUT && P_STORE_BYTES > 1) begin
                    r_tlast <= 1'b0;
                    r_busy  <= 1'b1;
                    r_cnt   <= CW'(1);
                    r_data  <= i_job_data >> 8;
                end else begin
                    r_tlast <= 1'b1;
                end
            end else begin
                r_tvalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
